FILE: sv/imtm_pkg.sv
// shared types, widths and constants of the imu nearest timestamp matcher
// no dependencies; imported by every module of the block but imtm_ram
package imtm_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int TS_W    = 48;
   localparam int ACC_W   = 32;
   localparam int QUAT_W  = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int PL_W    = 3 * ACC_W + 4 * QUAT_W;

   localparam logic [CSR_W-1:0] TS_SHIFT_RESET        = 32'd0;
   localparam logic [CSR_W-1:0] BUFFER_WINDOW_RESET   = 32'd2000000;
   localparam logic [CSR_W-1:0] MATCH_THRESHOLD_RESET = 32'd200000;

   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TS_SHIFT        = 2'd0,
      CSR_BUFFER_WINDOW   = 2'd1,
      CSR_MATCH_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_WR,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_Q_RD_OLD,
      ST_Q_CHK_OLD,
      ST_Q_CHK_NEW,
      ST_Q_SCAN,
      ST_Q_FETCH,
      ST_Q_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_OLDEST,
      RD_NEWEST,
      RD_SCAN
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       wr_push;
      logic       drop;
      logic       chk_old;
      logic       chk_new;
      logic       scan_init;
      logic       scan_run;
      logic       load_rsp;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic drop_ok;
      logic fail;
      logic scan_done;
      logic out_free;
   } status_type;

   // two's complement negate, most negative value saturates
   function automatic logic [QUAT_W-1:0] neg_sat16(input logic [QUAT_W-1:0] v);
      logic [QUAT_W-1:0] r;
      if (v == {1'b1, {(QUAT_W-1){1'b0}}}) begin
         r = {1'b0, {(QUAT_W-1){1'b1}}};
      end else begin
         r = ~v + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: sv/imu_nearest_timestamp_matcher_core.sv
// top level of the imu nearest timestamp matcher
// depends on imtm_pkg, imtm_ctrl, imtm_dp (which holds two imtm_ram stores)
//
// keeps a ring of up to DEPTH imu samples and, for a keyframe time, returns the
// sample whose timestamp is nearest. a push word (func 0) has the signed offset
// register added to its timestamp, clamped to 0..2^48-1, is appended
// (overwriting the oldest sample when the ring is full) and then the oldest
// samples older than buffer_window relative to the new one are dropped. a query
// word (func 1) gives one result word: no match with all fields zero if the ring
// is empty or the time lies outside the oldest..newest span, otherwise the
// nearest sample, with the first of equal distances winning, matched only if the
// distance is below match_threshold, quaternion flipped to a non-negative w.
// sequence: the input side takes one word at a time. a push writes the sample,
// then reads and compares the oldest, repeating for each sample dropped, over
// the single read port of the time store. a query checks the oldest and newest
// times, then scans with the scan pipeline reading one stored time per cycle;
// one failing the span check skips the scan, one on an empty ring both. a query
// whose result cannot yet go out waits until the result register is free.
// pushes do not produce result words. the stores need no clearing after reset.
module imu_nearest_timestamp_matcher_core
   import imtm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [TS_W-1:0]          req_timestamp,
   input  logic signed [ACC_W-1:0]  req_accel_x,
   input  logic signed [ACC_W-1:0]  req_accel_y,
   input  logic signed [ACC_W-1:0]  req_accel_z,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_matched,
   output logic [TS_W-1:0]          rsp_time_diff,
   output logic signed [ACC_W-1:0]  rsp_match_accel_x,
   output logic signed [ACC_W-1:0]  rsp_match_accel_y,
   output logic signed [ACC_W-1:0]  rsp_match_accel_z,
   output logic signed [QUAT_W-1:0] rsp_match_quat_w,
   output logic signed [QUAT_W-1:0] rsp_match_quat_x,
   output logic signed [QUAT_W-1:0] rsp_match_quat_y,
   output logic signed [QUAT_W-1:0] rsp_match_quat_z,
   // register write port
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one word in flight, walks push trim or query scan
   imtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, ring pointers, stores, scan and result register
   imtm_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_timestamp     (req_timestamp),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_quat_w        (req_quat_w),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_time_diff     (rsp_time_diff),
      .rsp_match_accel_x (rsp_match_accel_x),
      .rsp_match_accel_y (rsp_match_accel_y),
      .rsp_match_accel_z (rsp_match_accel_z),
      .rsp_match_quat_w  (rsp_match_quat_w),
      .rsp_match_quat_x  (rsp_match_quat_x),
      .rsp_match_quat_y  (rsp_match_quat_y),
      .rsp_match_quat_z  (rsp_match_quat_z)
   );

endmodule

FILE: sv/imtm_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module imtm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/imtm_ctrl.sv
// sequencer for push, age trimming, span check, scan and result hand-off
// depends on imtm_pkg
module imtm_ctrl
   import imtm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_OLDEST;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_QUERY) begin
                  state_in = status.empty ? ST_Q_DONE : ST_Q_RD_OLD;
               end else begin
                  state_in = ST_PUSH_WR;
               end
            end
         end
         ST_PUSH_WR: begin
            cmd.wr_push = 1'b1;
            state_in    = ST_PUSH_RD;
         end
         ST_PUSH_RD: begin
            cmd.rd_sel = RD_OLDEST;
            state_in   = ST_PUSH_CMP;
         end
         ST_PUSH_CMP: begin
            if (status.drop_ok) begin
               cmd.drop = 1'b1;
               state_in = ST_PUSH_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_Q_RD_OLD: begin
            cmd.rd_sel = RD_OLDEST;
            state_in   = ST_Q_CHK_OLD;
         end
         ST_Q_CHK_OLD: begin
            cmd.chk_old = 1'b1;
            cmd.rd_sel  = RD_NEWEST;
            state_in    = ST_Q_CHK_NEW;
         end
         ST_Q_CHK_NEW: begin
            cmd.chk_new   = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_Q_SCAN;
         end
         ST_Q_SCAN: begin
            if (status.fail) begin
               state_in = ST_Q_DONE;
            end else begin
               cmd.scan_run = 1'b1;
               cmd.rd_sel   = RD_SCAN;
               if (status.scan_done) begin
                  state_in = ST_Q_FETCH;
               end
            end
         end
         ST_Q_FETCH: begin
            state_in = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/imtm_dp.sv
// datapath: config registers, ring pointers, sample stores, scan pipeline
// and the result register; depends on imtm_pkg and imtm_ram
module imtm_dp
   import imtm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic                        req_func,
   input  logic [TS_W-1:0]             req_timestamp,
   input  logic signed [ACC_W-1:0]     req_accel_x,
   input  logic signed [ACC_W-1:0]     req_accel_y,
   input  logic signed [ACC_W-1:0]     req_accel_z,
   input  logic signed [QUAT_W-1:0]    req_quat_w,
   input  logic signed [QUAT_W-1:0]    req_quat_x,
   input  logic signed [QUAT_W-1:0]    req_quat_y,
   input  logic signed [QUAT_W-1:0]    req_quat_z,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_matched,
   output logic [TS_W-1:0]             rsp_time_diff,
   output logic signed [ACC_W-1:0]     rsp_match_accel_x,
   output logic signed [ACC_W-1:0]     rsp_match_accel_y,
   output logic signed [ACC_W-1:0]     rsp_match_accel_z,
   output logic signed [QUAT_W-1:0]    rsp_match_quat_w,
   output logic signed [QUAT_W-1:0]    rsp_match_quat_x,
   output logic signed [QUAT_W-1:0]    rsp_match_quat_y,
   output logic signed [QUAT_W-1:0]    rsp_match_quat_z
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // configuration
   logic [CSR_W-1:0] ts_shift_ff, buffer_window_ff, match_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_shift_ff        <= TS_SHIFT_RESET;
         buffer_window_ff   <= BUFFER_WINDOW_RESET;
         match_threshold_ff <= MATCH_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TS_SHIFT:        ts_shift_ff        <= csr_wdata;
            CSR_BUFFER_WINDOW:   buffer_window_ff   <= csr_wdata;
            CSR_MATCH_THRESHOLD: match_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // incoming word capture: shifted and clamped time for a push, raw for a query
   logic signed [TS_W+1:0] shifted;
   logic [TS_W-1:0]        clamped;
   logic [TS_W-1:0]        key_ff, key_in;
   logic [PL_W-1:0]        payload_ff;

   always_comb begin
      shifted = $signed({2'b00, req_timestamp})
              + $signed({{(TS_W+2-CSR_W){ts_shift_ff[CSR_W-1]}}, ts_shift_ff});
      if (shifted[TS_W+1]) begin
         clamped = '0;
      end else if (shifted[TS_W]) begin
         clamped = '1;
      end else begin
         clamped = shifted[TS_W-1:0];
      end
      key_in = (req_func == FUNC_QUERY) ? req_timestamp : clamped;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff     <= key_in;
         payload_ff <= {req_accel_x, req_accel_y, req_accel_z,
                        req_quat_w, req_quat_x, req_quat_y, req_quat_z};
      end
   end

   // ring pointers
   logic [IDX_W-1:0] oldest_ff, oldest_in, oldest_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic [SUM_W-1:0] tail_sum, newest_sum;
   logic [IDX_W-1:0] tail_slot, newest_slot;

   always_comb begin
      full        = (count_ff == CNT_W'(DEPTH));
      oldest_next = (oldest_ff == IDX_W'(DEPTH - 1)) ? '0 : oldest_ff + 1'b1;

      tail_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(DEPTH);
      end
      // when full the new word overwrites the oldest slot
      tail_slot = full ? oldest_ff : tail_sum[IDX_W-1:0];

      newest_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff) - 1'b1;
      if (newest_sum >= SUM_W'(DEPTH)) begin
         newest_sum = newest_sum - SUM_W'(DEPTH);
      end
      newest_slot = newest_sum[IDX_W-1:0];

      oldest_in = oldest_ff;
      count_in  = count_ff;
      if (cmd.wr_push) begin
         if (full) begin
            oldest_in = oldest_next;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.drop) begin
         oldest_in = oldest_next;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   // stores
   logic [IDX_W-1:0] time_rd_addr;
   logic [TS_W-1:0]  time_rd;
   logic [IDX_W-1:0] scan_ptr_ff;
   logic [IDX_W-1:0] best_slot_ff;
   logic [PL_W-1:0]  pl_rd;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_OLDEST: time_rd_addr = oldest_ff;
         RD_NEWEST: time_rd_addr = newest_slot;
         RD_SCAN:   time_rd_addr = scan_ptr_ff;
         default:   time_rd_addr = oldest_ff;
      endcase
   end

   imtm_ram #(
      .WIDTH (TS_W),
      .DEPTH (DEPTH)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_push),
      .wr_addr (tail_slot),
      .wr_data (key_ff),
      .rd_addr (time_rd_addr),
      .rd_data (time_rd)
   );

   imtm_ram #(
      .WIDTH (PL_W),
      .DEPTH (DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_push),
      .wr_addr (tail_slot),
      .wr_data (payload_ff),
      .rd_addr (best_slot_ff),
      .rd_data (pl_rd)
   );

   // age trim test against the oldest word
   assign status.drop_ok = (key_ff > time_rd)
                         && ((key_ff - time_rd) > TS_W'(buffer_window_ff));

   // span check: empty buffer or query outside oldest..newest
   logic fail_ff, fail_in;

   always_comb begin
      fail_in = fail_ff;
      if (cmd.load) begin
         fail_in = (count_ff == '0);
      end else if (cmd.chk_old) begin
         fail_in = fail_ff | (key_ff < time_rd);
      end else if (cmd.chk_new) begin
         fail_in = fail_ff | (key_ff > time_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff <= 1'b0;
      end else begin
         fail_ff <= fail_in;
      end
   end

   assign status.fail  = fail_ff;
   assign status.empty = (count_ff == '0);

   // scan pipeline: issue read, form |t - q|, compare with best
   logic [CNT_W-1:0] issue_k_ff, eval_k_ff;
   logic             v1_ff, v2_ff;
   logic [IDX_W-1:0] s1_ff, s2_ff;
   logic [TS_W-1:0]  dt2_ff, best_ff;
   logic             gt2_ff, have_ff;
   logic             issuing, upd, brk, last;

   always_comb begin
      issuing = cmd.scan_run && (issue_k_ff != count_ff);
      upd     = !have_ff || (dt2_ff < best_ff);
      brk     = have_ff && gt2_ff && (dt2_ff > best_ff);
      last    = (eval_k_ff == count_ff - 1'b1);
   end

   assign status.scan_done = v2_ff && (brk || last);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= issuing;
         v2_ff <= cmd.scan_run && v1_ff;
         if (cmd.scan_run && v2_ff && upd) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         issue_k_ff  <= '0;
         eval_k_ff   <= '0;
         scan_ptr_ff <= oldest_ff;
         best_ff     <= '0;
      end else begin
         if (issuing) begin
            issue_k_ff  <= issue_k_ff + 1'b1;
            scan_ptr_ff <= (scan_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : scan_ptr_ff + 1'b1;
         end
         if (cmd.scan_run && v2_ff) begin
            eval_k_ff <= eval_k_ff + 1'b1;
            if (upd) begin
               best_ff      <= dt2_ff;
               best_slot_ff <= s2_ff;
            end
         end
      end
      s1_ff  <= scan_ptr_ff;
      s2_ff  <= s1_ff;
      gt2_ff <= (time_rd > key_ff);
      dt2_ff <= (time_rd >= key_ff) ? time_rd - key_ff : key_ff - time_rd;
   end

   // result register, reloaded as soon as the previous word is taken
   logic                     rsp_valid_ff;
   logic                     matched;
   logic [QUAT_W-1:0]        qw, qx, qy, qz;
   logic                     flip;
   logic                     matched_ff;
   logic [TS_W-1:0]          time_diff_ff;
   logic [ACC_W-1:0]         ax_ff, ay_ff, az_ff;
   logic [QUAT_W-1:0]        qw_ff, qx_ff, qy_ff, qz_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      matched = !fail_ff && (best_ff < TS_W'(match_threshold_ff));
      qw      = pl_rd[4*QUAT_W-1:3*QUAT_W];
      qx      = pl_rd[3*QUAT_W-1:2*QUAT_W];
      qy      = pl_rd[2*QUAT_W-1:QUAT_W];
      qz      = pl_rd[QUAT_W-1:0];
      flip    = qw[QUAT_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         matched_ff   <= matched;
         time_diff_ff <= fail_ff ? '0 : best_ff;
         if (matched) begin
            ax_ff <= pl_rd[PL_W-1:PL_W-ACC_W];
            ay_ff <= pl_rd[PL_W-ACC_W-1:PL_W-2*ACC_W];
            az_ff <= pl_rd[PL_W-2*ACC_W-1:4*QUAT_W];
            qw_ff <= flip ? neg_sat16(qw) : qw;
            qx_ff <= flip ? neg_sat16(qx) : qx;
            qy_ff <= flip ? neg_sat16(qy) : qy;
            qz_ff <= flip ? neg_sat16(qz) : qz;
         end else begin
            ax_ff <= '0;
            ay_ff <= '0;
            az_ff <= '0;
            qw_ff <= '0;
            qx_ff <= '0;
            qy_ff <= '0;
            qz_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = matched_ff;
   assign rsp_time_diff     = time_diff_ff;
   assign rsp_match_accel_x = ax_ff;
   assign rsp_match_accel_y = ay_ff;
   assign rsp_match_accel_z = az_ff;
   assign rsp_match_quat_w  = qw_ff;
   assign rsp_match_quat_x  = qx_ff;
   assign rsp_match_quat_y  = qy_ff;
   assign rsp_match_quat_z  = qz_ff;

endmodule
